// ===== rtl/tfn_pkg.sv =====
`timescale 1ns / 1ps
package tfn_pkg;

	localparam int MAG_BITS  = 31;
	localparam int SUM_BITS  = 64;
	localparam int ROOT_BITS = 32;
	localparam int IDX_BITS  = 16;
	localparam int OUT_BITS  = 16;
	localparam int QMAX      = 32767;

	// register index as decoded from paddr[2]
	localparam logic REG_FACE_COUNT = 1'b0;

	typedef struct packed {
		logic [IDX_BITS-1:0] idx_a;
		logic [IDX_BITS-1:0] idx_b;
		logic [IDX_BITS-1:0] idx_c;
		logic                last;
	} tfn_side_t;

	typedef struct packed {
		logic [2:0][MAG_BITS-1:0] mag;
		logic [2:0]               neg;
		logic                     degen;
		tfn_side_t                side;
	} tfn_pl_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] nx;
		logic signed [OUT_BITS-1:0] ny;
		logic signed [OUT_BITS-1:0] nz;
		logic                       degen;
		tfn_side_t                  side;
	} tfn_res_t;

endpackage

// ===== rtl/tfn_sqrt_cell.sv =====
`timescale 1ns / 1ps
// one digit of the integer square root, bit weight 4^BIT_POS
module tfn_sqrt_cell #(
	parameter int BIT_POS = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [tfn_pkg::SUM_BITS-1:0]      in_v,
	input  logic [tfn_pkg::SUM_BITS-1:0]      in_r,
	input  tfn_pkg::tfn_pl_t                  in_pl,
	output logic                              out_vld,
	output logic [tfn_pkg::SUM_BITS-1:0]      out_v,
	output logic [tfn_pkg::SUM_BITS-1:0]      out_r,
	output tfn_pkg::tfn_pl_t                  out_pl
);

	localparam logic [tfn_pkg::SUM_BITS-1:0] BIT_W =
		tfn_pkg::SUM_BITS'(1) << (2 * BIT_POS);

	logic [tfn_pkg::SUM_BITS-1:0] trial;
	logic [tfn_pkg::SUM_BITS-1:0] nv;
	logic [tfn_pkg::SUM_BITS-1:0] nr;

	always_comb begin
		trial = in_r + BIT_W;
		if (in_v >= trial) begin
			nv = in_v - trial;
			nr = (in_r >> 1) + BIT_W;
		end else begin
			nv = in_v;
			nr = in_r >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_v  <= nv;
			out_r  <= nr;
			out_pl <= in_pl;
		end
	end

endmodule

// ===== rtl/tfn_div_cell.sv =====
`timescale 1ns / 1ps
// one quotient bit (weight 2^K) for all three components against a shared divisor
module tfn_div_cell #(
	parameter int NW = 47,
	parameter int QW = 15,
	parameter int K  = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic [tfn_pkg::ROOT_BITS-1:0]    in_len,
	input  logic [2:0][NW-1:0]               in_rem,
	input  logic [2:0][QW-1:0]               in_q,
	input  tfn_pkg::tfn_pl_t                 in_pl,
	output logic                             out_vld,
	output logic [tfn_pkg::ROOT_BITS-1:0]    out_len,
	output logic [2:0][NW-1:0]               out_rem,
	output logic [2:0][QW-1:0]               out_q,
	output tfn_pkg::tfn_pl_t                 out_pl
);

	logic [NW-1:0]        dvs;
	logic [2:0][NW-1:0]   nrem;
	logic [2:0][QW-1:0]   nq;

	always_comb begin
		dvs = NW'(in_len) << K;
		for (int i = 0; i < 3; i++) begin
			nrem[i] = in_rem[i];
			nq[i]   = in_q[i];
			if (in_rem[i] >= dvs) begin
				nrem[i]  = in_rem[i] - dvs;
				nq[i][K] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_len <= in_len;
			out_rem <= nrem;
			out_q   <= nq;
			out_pl  <= in_pl;
		end
	end

endmodule

// ===== rtl/triangle_face_normal_unit.sv =====
`timescale 1ns / 1ps
// Unit face normal of one triangle per transfer.
// Input channel (in_valid / in_stall) carries corners a, b, c and three vertex
// indices; the output channel (out_valid / out_stall) returns the normal
// (c - a) x (b - a) scaled to unit length in signed Q1.NORMAL_FRAC_BITS,
// the indices, a degenerate flag for a zero cross product and last_face.
// last_face marks every face_count-th face; face_count is written over the
// APB port at byte address 0 and reads back there.
// Throughput: one triangle per cycle while in_stall is low. The pipeline is
// built from six front stages, 32 square-root cells, a numerator stage,
// NORMAL_FRAC_BITS+1 divide cells and the output register.
// Reset empties the pipeline, clears the face counter and sets face_count
// to 1.
// When the receiver stalls, the result holds in the output register and one
// more result lands in a skid register; in_stall rises only once the skid
// register is full, and the whole pipeline then holds until it drains.
module triangle_face_normal_unit #(
	parameter int COORD_BITS       = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] az,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by_coord,
	input  logic signed [COORD_BITS-1:0] bz,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] cz,
	input  logic [15:0]            index_a,
	input  logic [15:0]            index_b,
	input  logic [15:0]            index_c,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [15:0]     normal_x,
	output logic signed [15:0]     normal_y,
	output logic signed [15:0]     normal_z,
	output logic [15:0]            out_index_a,
	output logic [15:0]            out_index_b,
	output logic [15:0]            out_index_c,
	output logic                   degenerate,
	output logic                   last_face
);

	localparam int DW  = (COORD_BITS + 1 > 31) ? 32 : COORD_BITS + 1;
	localparam int SH  = (COORD_BITS + 1 > 31) ? COORD_BITS - 30 : 0;
	localparam int PW  = 2 * DW;
	localparam int CW  = PW + 1;
	localparam int MW  = PW;
	localparam int EXW = $clog2(MW + 1);
	localparam int F   = NORMAL_FRAC_BITS;
	localparam int QW  = F + 1;
	localparam int NW  = F + 33;
	localparam int NSQ = tfn_pkg::ROOT_BITS;
	localparam int MB  = tfn_pkg::MAG_BITS;

	// ---------------- configuration and face counter
	logic [15:0] face_count_q;
	logic [15:0] face_ctr_q;
	logic        cfg_wr;
	logic        en;
	logic        accept;
	logic        is_last;
	logic        skid_valid_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == tfn_pkg::REG_FACE_COUNT) ? {16'd0, face_count_q} : 32'd0;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign is_last  = face_ctr_q == (face_count_q - 16'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_count_q <= 16'd1;
			face_ctr_q   <= 16'd0;
		end else begin
			if (cfg_wr && paddr[2] == tfn_pkg::REG_FACE_COUNT) begin
				face_count_q <= pwdata[15:0];
			end
			if (accept) begin
				face_ctr_q <= is_last ? 16'd0 : face_ctr_q + 16'd1;
			end
		end
	end

	// ---------------- stage 1: edge vectors u = c - a, v = b - a
	logic signed [COORD_BITS-1:0] pc [6];
	logic signed [COORD_BITS-1:0] qc [6];
	logic signed [COORD_BITS:0]   dfull [6];
	logic [COORD_BITS:0]          dmag [6];
	logic [COORD_BITS:0]          dsh [6];
	logic signed [DW-1:0]         dres [6];

	assign pc[0] = cx;  assign pc[1] = cy;       assign pc[2] = cz;
	assign pc[3] = bx;  assign pc[4] = by_coord; assign pc[5] = bz;
	assign qc[0] = ax;  assign qc[1] = ay;       assign qc[2] = az;
	assign qc[3] = ax;  assign qc[4] = ay;       assign qc[5] = az;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			dfull[i] = {pc[i][COORD_BITS-1], pc[i]} - {qc[i][COORD_BITS-1], qc[i]};
			dmag[i]  = dfull[i][COORD_BITS] ? $unsigned(-dfull[i]) : $unsigned(dfull[i]);
			dsh[i]   = dmag[i] >> SH;
			dres[i]  = dfull[i][COORD_BITS] ? -$signed(dsh[i][DW-1:0])
			                                 :  $signed(dsh[i][DW-1:0]);
		end
	end

	logic                  valid_s1;
	logic signed [DW-1:0]  d_s1 [6];
	tfn_pkg::tfn_side_t    side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1         <= dres;
			side_s1.idx_a <= index_a;
			side_s1.idx_b <= index_b;
			side_s1.idx_c <= index_c;
			side_s1.last  <= is_last;
		end
	end

	// ---------------- stage 2: six products of the cross product
	// order: uy*vz, uz*vy, uz*vx, ux*vz, ux*vy, uy*vx
	logic                  valid_s2;
	logic signed [PW-1:0]  prod_s2 [6];
	tfn_pkg::tfn_side_t    side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2[0] <= d_s1[1] * d_s1[5];
			prod_s2[1] <= d_s1[2] * d_s1[4];
			prod_s2[2] <= d_s1[2] * d_s1[3];
			prod_s2[3] <= d_s1[0] * d_s1[5];
			prod_s2[4] <= d_s1[0] * d_s1[4];
			prod_s2[5] <= d_s1[1] * d_s1[3];
			side_s2    <= side_s1;
		end
	end

	// ---------------- stage 3: cross components as sign and magnitude
	logic signed [CW-1:0] cr [3];
	logic [MW-1:0]        crmag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i]    = CW'(prod_s2[2*i]) - CW'(prod_s2[2*i+1]);
			crmag[i] = cr[i][CW-1] ? MW'($unsigned(-cr[i])) : MW'($unsigned(cr[i]));
		end
	end

	logic               valid_s3;
	logic [MW-1:0]      mag_s3 [3];
	logic [2:0]         neg_s3;
	tfn_pkg::tfn_side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s3[i] <= crmag[i];
				neg_s3[i] <= cr[i][CW-1];
			end
			side_s3 <= side_s2;
		end
	end

	// ---------------- stage 4: bring the largest magnitude down to 31 bits
	logic [MW-1:0]  or_m;
	logic [EXW-1:0] excess;
	logic [MW-1:0]  shv [3];
	logic [MB-1:0]  m31 [3];

	always_comb begin
		or_m   = mag_s3[0] | mag_s3[1] | mag_s3[2];
		excess = '0;
		for (int b = MB; b < MW; b++) begin
			if (or_m[b]) begin
				excess = EXW'(b - (MB - 1));
			end
		end
		for (int i = 0; i < 3; i++) begin
			shv[i] = mag_s3[i] >> excess;
			m31[i] = MB'(shv[i]);
		end
	end

	logic               valid_s4;
	tfn_pkg::tfn_pl_t   pl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s4.mag[i] <= m31[i];
			end
			pl_s4.neg   <= neg_s3;
			pl_s4.degen <= (or_m == '0);
			pl_s4.side  <= side_s3;
		end
	end

	// ---------------- stage 5: squares, stage 6: sum of squares
	logic                         valid_s5;
	logic [2*MB-1:0]              sq_s5 [3];
	tfn_pkg::tfn_pl_t             pl_s5;
	logic                         valid_s6;
	logic [tfn_pkg::SUM_BITS-1:0] sum_s6;
	tfn_pkg::tfn_pl_t             pl_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= pl_s4.mag[i] * pl_s4.mag[i];
			end
			pl_s5  <= pl_s4;
			sum_s6 <= tfn_pkg::SUM_BITS'(sq_s5[0]) + tfn_pkg::SUM_BITS'(sq_s5[1])
			        + tfn_pkg::SUM_BITS'(sq_s5[2]);
			pl_s6  <= pl_s5;
		end
	end

	// ---------------- square root chain, one result bit per cell
	logic                         sq_vld [NSQ+1];
	logic [tfn_pkg::SUM_BITS-1:0] sq_v   [NSQ+1];
	logic [tfn_pkg::SUM_BITS-1:0] sq_r   [NSQ+1];
	tfn_pkg::tfn_pl_t             sq_pl  [NSQ+1];

	assign sq_vld[0] = valid_s6;
	assign sq_v[0]   = sum_s6;
	assign sq_r[0]   = '0;
	assign sq_pl[0]  = pl_s6;

	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		tfn_sqrt_cell #(
			.BIT_POS(NSQ - 1 - j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (sq_vld[j]),
			.in_v   (sq_v[j]),
			.in_r   (sq_r[j]),
			.in_pl  (sq_pl[j]),
			.out_vld(sq_vld[j+1]),
			.out_v  (sq_v[j+1]),
			.out_r  (sq_r[j+1]),
			.out_pl (sq_pl[j+1])
		);
	end

	// ---------------- numerator with half the length for rounding
	logic [tfn_pkg::ROOT_BITS-1:0] len;
	logic                          valid_nm;
	logic [tfn_pkg::ROOT_BITS-1:0] len_nm;
	logic [2:0][NW-1:0]            rem_nm;
	tfn_pkg::tfn_pl_t              pl_nm;

	assign len = sq_r[NSQ][tfn_pkg::ROOT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_nm <= 1'b0;
		end else if (en) begin
			valid_nm <= sq_vld[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_nm <= len;
			for (int i = 0; i < 3; i++) begin
				rem_nm[i] <= (NW'(sq_pl[NSQ].mag[i]) << F) + NW'(len >> 1);
			end
			pl_nm <= sq_pl[NSQ];
		end
	end

	// ---------------- divide chain, quotient bits from weight 2^F down
	logic                          dv_vld [QW+1];
	logic [tfn_pkg::ROOT_BITS-1:0] dv_len [QW+1];
	logic [2:0][NW-1:0]            dv_rem [QW+1];
	logic [2:0][QW-1:0]            dv_q   [QW+1];
	tfn_pkg::tfn_pl_t              dv_pl  [QW+1];

	assign dv_vld[0] = valid_nm;
	assign dv_len[0] = len_nm;
	assign dv_rem[0] = rem_nm;
	assign dv_q[0]   = '0;
	assign dv_pl[0]  = pl_nm;

	for (genvar j = 0; j < QW; j++) begin : g_div
		tfn_div_cell #(
			.NW(NW),
			.QW(QW),
			.K (QW - 1 - j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (dv_vld[j]),
			.in_len (dv_len[j]),
			.in_rem (dv_rem[j]),
			.in_q   (dv_q[j]),
			.in_pl  (dv_pl[j]),
			.out_vld(dv_vld[j+1]),
			.out_len(dv_len[j+1]),
			.out_rem(dv_rem[j+1]),
			.out_q  (dv_q[j+1]),
			.out_pl (dv_pl[j+1])
		);
	end

	// ---------------- saturate, apply sign, zero a degenerate face
	tfn_pkg::tfn_res_t pres;
	logic [14:0]       sat [3];
	logic signed [15:0] sval [3];
	tfn_pkg::tfn_pl_t  fpl;

	assign fpl = dv_pl[QW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat[i] = (32'(dv_q[QW][i]) > 32'(tfn_pkg::QMAX)) ? 15'(tfn_pkg::QMAX)
			                                                 : 15'(dv_q[QW][i]);
			if (fpl.degen) begin
				sval[i] = '0;
			end else if (fpl.neg[i]) begin
				sval[i] = -$signed({1'b0, sat[i]});
			end else begin
				sval[i] = $signed({1'b0, sat[i]});
			end
		end
		pres.nx    = sval[0];
		pres.ny    = sval[1];
		pres.nz    = sval[2];
		pres.degen = fpl.degen;
		pres.side  = fpl.side;
	end

	// ---------------- output register with skid stage
	logic              out_valid_q;
	tfn_pkg::tfn_res_t out_q;
	tfn_pkg::tfn_res_t skid_q;
	logic              out_free;
	logic              incoming;

	assign out_free = !out_valid_q || !out_stall;
	assign incoming = en && dv_vld[QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (incoming) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (incoming) begin
			if (out_free) begin
				out_q <= pres;
			end else begin
				skid_q <= pres;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign normal_x    = out_q.nx;
	assign normal_y    = out_q.ny;
	assign normal_z    = out_q.nz;
	assign out_index_a = out_q.side.idx_a;
	assign out_index_b = out_q.side.idx_b;
	assign out_index_c = out_q.side.idx_c;
	assign degenerate  = out_q.degen;
	assign last_face   = out_q.side.last;

	// ---------------- checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while output register is empty");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && degenerate) |-> (normal_x == 16'sd0 && normal_y == 16'sd0
		                                 && normal_z == 16'sd0))
		else $error("degenerate face with nonzero normal");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid register filled without a stalled output");

endmodule
